@@ rtl/aebl_pkg.sv @@
// ----------------------------------------------------------------------------
// aebl_pkg: shared types and constants for the arc endpoint block
// Fixed-point widths, request and response payloads, CORDIC cell and divider
// cell data, and the arctangent table in fractions of a turn.
// ----------------------------------------------------------------------------
package aebl_pkg;

    localparam int COORD_BITS    = 24;
    localparam int LEN_BITS      = 24;
    localparam int CORDIC_STAGES = 24;
    localparam int GUARD_BITS    = 16;
    localparam int ZW            = 32;

    // offset width, scaled offset width with headroom for CORDIC gain
    localparam int DX_W   = COORD_BITS + 1;
    localparam int XW     = DX_W + GUARD_BITS + 3;
    localparam int RQ_W   = XW - 1;
    localparam int HI_W   = RQ_W - 32;
    localparam int REM_W  = RQ_W + 1;
    localparam int INV2_W = 30;
    localparam int NUM_W  = LEN_BITS + INV2_W;
    localparam int DIVN_W = NUM_W + GUARD_BITS;
    localparam int OFS_W  = XW - GUARD_BITS;
    localparam int SUM_W  = OFS_W + 1;

    localparam logic [31:0]       INV_GAIN  = 32'd2608131496;
    localparam logic [INV2_W-1:0] INV_2PI   = 30'd683565276;
    localparam logic [ZW-1:0]     HALF_TURN = 32'h8000_0000;

    localparam logic signed [XW-1:0] ROUND_HALF =
        {{(XW - GUARD_BITS){1'b0}}, 1'b1, {(GUARD_BITS - 1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic [LEN_BITS-1:0]          arc_length;
        logic                         turn_clockwise;
    } req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic                         zero_radius;
        logic                         clipped;
    } rsp_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [ZW-1:0]        z;
    } cord_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [LEN_BITS-1:0]          len;
        logic                         cw;
        logic                         zero;
    } cside_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIVN_W-1:0] numer;
        logic [ZW-1:0]     quo;
        logic [RQ_W-1:0]   rq;
    } div_t;

    typedef struct packed {
        logic [ZW-1:0]                z;
        logic                         cw;
        logic [RQ_W-1:0]              amp;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic                         zero;
    } dside_t;

    function automatic logic [ZW-1:0] atan_turn(input logic [4:0] idx);
        logic [ZW-1:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/aebl_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// aebl_cordic_cell: one registered CORDIC micro-rotation
// Vectoring steers on the sign of y, rotation on the sign of the residual
// angle; the side data rides along with the request.
// ----------------------------------------------------------------------------
module aebl_cordic_cell
    import aebl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [4:0] idx,
    input  logic       rotate,
    input  logic       a_valid,
    input  cord_t      a_cord,
    input  cside_t     a_side,
    output logic       b_valid,
    output cord_t      b_cord,
    output cside_t     b_side
);

    logic   valid_reg;
    cord_t  cord_reg, cord_next;
    cside_t side_reg;

    always_comb
    begin
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic                 up;
        xs = a_cord.x >>> idx;
        ys = a_cord.y >>> idx;
        up = rotate ? a_cord.z[ZW-1] : ~a_cord.y[XW-1];
        if (up)
        begin
            cord_next.x = a_cord.x + ys;
            cord_next.y = a_cord.y - xs;
            cord_next.z = a_cord.z + atan_turn(idx);
        end
        else
        begin
            cord_next.x = a_cord.x - ys;
            cord_next.y = a_cord.y + xs;
            cord_next.z = a_cord.z - atan_turn(idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= a_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cord_reg <= cord_next;
            side_reg <= a_side;
        end
    end

    assign b_valid = valid_reg;
    assign b_cord  = cord_reg;
    assign b_side  = side_reg;

endmodule

@@ rtl/aebl_div_cell.sv @@
// ----------------------------------------------------------------------------
// aebl_div_cell: one registered restoring-division step
// Brings down one numerator bit, subtracts the divisor when it fits and
// shifts the quotient bit in.
// ----------------------------------------------------------------------------
module aebl_div_cell
    import aebl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   a_valid,
    input  div_t   a_div,
    input  dside_t a_side,
    output logic   b_valid,
    output div_t   b_div,
    output dside_t b_side
);

    logic   valid_reg;
    div_t   div_reg, div_next;
    dside_t side_reg;

    always_comb
    begin
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] d;
        logic             fits;
        r2   = {a_div.rem[REM_W-2:0], a_div.numer[DIVN_W-1]};
        d    = {1'b0, a_div.rq};
        fits = (r2 >= d);
        div_next.rem   = fits ? (r2 - d) : r2;
        div_next.numer = {a_div.numer[DIVN_W-2:0], 1'b0};
        div_next.quo   = {a_div.quo[ZW-2:0], fits};
        div_next.rq    = a_div.rq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= a_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_next;
            side_reg <= a_side;
        end
    end

    assign b_valid = valid_reg;
    assign b_div   = div_reg;
    assign b_side  = side_reg;

endmodule

@@ rtl/arc_endpoint_by_length.sv @@
// ----------------------------------------------------------------------------
// arc_endpoint_by_length: end point of an arc of given length
// Vectoring CORDIC, length-over-radius divider and rotation CORDIC, all as
// chains of registered cells.
// ----------------------------------------------------------------------------
// usage
//   req channel: req_valid / req_ready / req_data carry start point, centre,
//   arc length and direction. rsp channel: rsp_valid / rsp_ready / rsp_data
//   carry end point, zero_radius and clipped, one response per request.
//   throughput: one request per cycle sustained; a request enters whenever
//   the response register is empty or being taken in the same cycle.
//   pipeline: offset and fold stages, the vectoring chain, the radius and
//   amplitude multiply stages, the 70 divider cells of one quotient bit each,
//   end angle and half plane stages, the rotation chain, rounding and response.
//   stall: when rsp_valid is high and rsp_ready low, the whole pipe holds
//   and req_ready drops in the same cycle; nothing is lost or repeated.
//   reset: rst_n clears every valid bit, the pipe comes up empty.
//   a start point equal to the centre returns the centre with zero_radius.
// ----------------------------------------------------------------------------
module arc_endpoint_by_length
    import aebl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    logic en;
    logic rsp_valid_reg;
    rsp_t rsp_data_reg, rsp_data_next;

    assign en = ~rsp_valid_reg | rsp_ready;

    // offsets from the centre
    logic                   s0_valid_reg;
    logic signed [DX_W-1:0] s0_dx_reg, s0_dy_reg;
    cside_t                 s0_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dx_reg <= {req_data.start_x[COORD_BITS-1], req_data.start_x}
                       - {req_data.center_x[COORD_BITS-1], req_data.center_x};
            s0_dy_reg <= {req_data.start_y[COORD_BITS-1], req_data.start_y}
                       - {req_data.center_y[COORD_BITS-1], req_data.center_y};
            s0_side_reg.cx   <= req_data.center_x;
            s0_side_reg.cy   <= req_data.center_y;
            s0_side_reg.len  <= req_data.arc_length;
            s0_side_reg.cw   <= req_data.turn_clockwise;
            s0_side_reg.zero <= (req_data.start_x == req_data.center_x)
                             && (req_data.start_y == req_data.center_y);
        end
    end

    // scale and fold into the right half plane
    logic   s1_valid_reg;
    cord_t  s1_cord_reg, s1_cord_next;
    cside_t s1_side_reg;

    always_comb
    begin
        logic signed [XW-1:0] xe;
        logic signed [XW-1:0] ye;
        xe = {{(XW - DX_W - GUARD_BITS){s0_dx_reg[DX_W-1]}}, s0_dx_reg,
              {GUARD_BITS{1'b0}}};
        ye = {{(XW - DX_W - GUARD_BITS){s0_dy_reg[DX_W-1]}}, s0_dy_reg,
              {GUARD_BITS{1'b0}}};
        if (s0_dx_reg[DX_W-1])
        begin
            s1_cord_next.x = -xe;
            s1_cord_next.y = -ye;
            s1_cord_next.z = HALF_TURN;
        end
        else
        begin
            s1_cord_next.x = xe;
            s1_cord_next.y = ye;
            s1_cord_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cord_reg <= s1_cord_next;
            s1_side_reg <= s0_side_reg;
        end
    end

    // vectoring chain
    logic   vec_v [0:CORDIC_STAGES];
    cord_t  vec_c [0:CORDIC_STAGES];
    cside_t vec_s [0:CORDIC_STAGES];

    assign vec_v[0] = s1_valid_reg;
    assign vec_c[0] = s1_cord_reg;
    assign vec_s[0] = s1_side_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_vec
        aebl_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .idx     (5'(g)),
            .rotate  (1'b0),
            .a_valid (vec_v[g]),
            .a_cord  (vec_c[g]),
            .a_side  (vec_s[g]),
            .b_valid (vec_v[g+1]),
            .b_cord  (vec_c[g+1]),
            .b_side  (vec_s[g+1])
        );
    end

    // radius: magnitude times 1/K, split into two partial products
    logic                m1_valid_reg;
    logic [HI_W+31:0]    m1_phi_reg;
    logic [31:0]         m1_plo_reg;
    logic [NUM_W-1:0]    m1_num_reg;
    logic [ZW-1:0]       m1_z_reg;
    cside_t              m1_side_reg;
    logic [RQ_W-1:0]     xv;
    logic [63:0]         m1_lo_prod;

    assign xv         = vec_c[CORDIC_STAGES].x[XW-1] ? '0 : vec_c[CORDIC_STAGES].x[RQ_W-1:0];
    assign m1_lo_prod = xv[31:0] * INV_GAIN;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_phi_reg  <= xv[RQ_W-1:32] * INV_GAIN;
            m1_plo_reg  <= m1_lo_prod[63:32];
            m1_num_reg  <= vec_s[CORDIC_STAGES].len * INV_2PI;
            m1_z_reg    <= vec_c[CORDIC_STAGES].z;
            m1_side_reg <= vec_s[CORDIC_STAGES];
        end
    end

    logic             m2_valid_reg;
    logic [RQ_W-1:0]  m2_rq_reg;
    logic [NUM_W-1:0] m2_num_reg;
    logic [ZW-1:0]    m2_z_reg;
    cside_t           m2_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_rq_reg   <= RQ_W'(m1_phi_reg + {{HI_W{1'b0}}, m1_plo_reg});
            m2_num_reg  <= m1_num_reg;
            m2_z_reg    <= m1_z_reg;
            m2_side_reg <= m1_side_reg;
        end
    end

    // rotation amplitude: radius times 1/K
    logic             m3_valid_reg;
    logic [HI_W+31:0] m3_ahi_reg;
    logic [31:0]      m3_alo_reg;
    logic [RQ_W-1:0]  m3_rq_reg;
    logic [NUM_W-1:0] m3_num_reg;
    logic [ZW-1:0]    m3_z_reg;
    cside_t           m3_side_reg;
    logic [63:0]      m3_lo_prod;

    assign m3_lo_prod = m2_rq_reg[31:0] * INV_GAIN;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_ahi_reg  <= m2_rq_reg[RQ_W-1:32] * INV_GAIN;
            m3_alo_reg  <= m3_lo_prod[63:32];
            m3_rq_reg   <= m2_rq_reg;
            m3_num_reg  <= m2_num_reg;
            m3_z_reg    <= m2_z_reg;
            m3_side_reg <= m2_side_reg;
        end
    end

    // divider chain: turn = length * 1/(2 pi) * 2^16 / radius
    logic   div_v [0:DIVN_W];
    div_t   div_d [0:DIVN_W];
    dside_t div_s [0:DIVN_W];

    assign div_v[0]       = m3_valid_reg;
    assign div_d[0].rem   = '0;
    assign div_d[0].numer = {m3_num_reg, {GUARD_BITS{1'b0}}};
    assign div_d[0].quo   = '0;
    assign div_d[0].rq    = m3_rq_reg;
    assign div_s[0].z     = m3_z_reg;
    assign div_s[0].cw    = m3_side_reg.cw;
    assign div_s[0].amp   = RQ_W'(m3_ahi_reg + {{HI_W{1'b0}}, m3_alo_reg});
    assign div_s[0].cx    = m3_side_reg.cx;
    assign div_s[0].cy    = m3_side_reg.cy;
    assign div_s[0].zero  = m3_side_reg.zero;

    for (genvar g = 0; g < DIVN_W; g++)
    begin : g_div
        aebl_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .a_valid (div_v[g]),
            .a_div   (div_d[g]),
            .a_side  (div_s[g]),
            .b_valid (div_v[g+1]),
            .b_div   (div_d[g+1]),
            .b_side  (div_s[g+1])
        );
    end

    // end angle
    logic            r0_valid_reg;
    logic [ZW-1:0]   r0_z_reg;
    logic [RQ_W-1:0] r0_amp_reg;
    cside_t          r0_side_reg;
    logic [ZW-1:0]   delta;

    assign delta = (div_d[DIVN_W].rq == '0) ? '0 : div_d[DIVN_W].quo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_z_reg <= div_s[DIVN_W].cw ? (div_s[DIVN_W].z - delta)
                                         : (div_s[DIVN_W].z + delta);
            r0_amp_reg       <= div_s[DIVN_W].amp;
            r0_side_reg.cx   <= div_s[DIVN_W].cx;
            r0_side_reg.cy   <= div_s[DIVN_W].cy;
            r0_side_reg.len  <= '0;
            r0_side_reg.cw   <= 1'b0;
            r0_side_reg.zero <= div_s[DIVN_W].zero;
        end
    end

    // left half plane: start from -amp and take a half turn off
    logic   r1_valid_reg;
    cord_t  r1_cord_reg, r1_cord_next;
    cside_t r1_side_reg;

    always_comb
    begin
        logic signed [XW-1:0] ax;
        ax = {1'b0, r0_amp_reg};
        r1_cord_next.y = '0;
        if (r0_z_reg[ZW-1] ^ r0_z_reg[ZW-2])
        begin
            r1_cord_next.x = -ax;
            r1_cord_next.z = r0_z_reg ^ HALF_TURN;
        end
        else
        begin
            r1_cord_next.x = ax;
            r1_cord_next.z = r0_z_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_cord_reg <= r1_cord_next;
            r1_side_reg <= r0_side_reg;
        end
    end

    // rotation chain
    logic   rot_v [0:CORDIC_STAGES];
    cord_t  rot_c [0:CORDIC_STAGES];
    cside_t rot_s [0:CORDIC_STAGES];

    assign rot_v[0] = r1_valid_reg;
    assign rot_c[0] = r1_cord_reg;
    assign rot_s[0] = r1_side_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_rot
        aebl_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .idx     (5'(g)),
            .rotate  (1'b1),
            .a_valid (rot_v[g]),
            .a_cord  (rot_c[g]),
            .a_side  (rot_s[g]),
            .b_valid (rot_v[g+1]),
            .b_cord  (rot_c[g+1]),
            .b_side  (rot_s[g+1])
        );
    end

    // round offsets half up to whole micrometres
    logic                    f1_valid_reg;
    logic signed [OFS_W-1:0] f1_ox_reg, f1_oy_reg;
    cside_t                  f1_side_reg;
    logic signed [XW-1:0]    rx, ry;

    assign rx = rot_c[CORDIC_STAGES].x + ROUND_HALF;
    assign ry = rot_c[CORDIC_STAGES].y + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_ox_reg   <= rx[XW-1:GUARD_BITS];
            f1_oy_reg   <= ry[XW-1:GUARD_BITS];
            f1_side_reg <= rot_s[CORDIC_STAGES];
        end
    end

    // add the centre back and saturate
    always_comb
    begin
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic                    ovx;
        logic                    ovy;
        sx = {{(SUM_W - COORD_BITS){f1_side_reg.cx[COORD_BITS-1]}}, f1_side_reg.cx}
           + {f1_ox_reg[OFS_W-1], f1_ox_reg};
        sy = {{(SUM_W - COORD_BITS){f1_side_reg.cy[COORD_BITS-1]}}, f1_side_reg.cy}
           + {f1_oy_reg[OFS_W-1], f1_oy_reg};
        ovx = (sx[SUM_W-1:COORD_BITS-1] != {(SUM_W - COORD_BITS + 1){sx[SUM_W-1]}});
        ovy = (sy[SUM_W-1:COORD_BITS-1] != {(SUM_W - COORD_BITS + 1){sy[SUM_W-1]}});
        if (f1_side_reg.zero)
        begin
            rsp_data_next.end_x       = f1_side_reg.cx;
            rsp_data_next.end_y       = f1_side_reg.cy;
            rsp_data_next.zero_radius = 1'b1;
            rsp_data_next.clipped     = 1'b0;
        end
        else
        begin
            rsp_data_next.end_x = ovx ? {sx[SUM_W-1], {(COORD_BITS - 1){~sx[SUM_W-1]}}}
                                      : sx[COORD_BITS-1:0];
            rsp_data_next.end_y = ovy ? {sy[SUM_W-1], {(COORD_BITS - 1){~sy[SUM_W-1]}}}
                                      : sy[COORD_BITS-1:0];
            rsp_data_next.zero_radius = 1'b0;
            rsp_data_next.clipped     = ovx | ovy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_data_reg <= rsp_data_next;
    end

    // valid bits of the stages outside the cell chains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            r0_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            f1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= req_valid;
            s1_valid_reg  <= s0_valid_reg;
            m1_valid_reg  <= vec_v[CORDIC_STAGES];
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            r0_valid_reg  <= div_v[DIVN_W];
            r1_valid_reg  <= r0_valid_reg;
            f1_valid_reg  <= rot_v[CORDIC_STAGES];
            rsp_valid_reg <= f1_valid_reg;
        end
    end

    assign req_ready = en;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
